// ----- hw/rtl/swsu_pkg.sv -----
// ----------------------------------------------------------------------------
// swsu_pkg
// Shared widths, codes and controller/datapath handshake types of the
// sliding window sender unit.
// ----------------------------------------------------------------------------
`default_nettype none

package swsu_pkg;

	// Default sizes handed to the top level parameters.
	localparam int WINDOW_DEPTH_DEF = 16;
	localparam int SEQ_COUNT_DEF    = 128;
	localparam int PAYLOAD_BITS_DEF = 64;

	// Fixed field widths of the channels.
	localparam int ACTION_W  = 2;
	localparam int PAYLOAD_W = 64;
	localparam int SEQ_W     = 7;
	localparam int KIND_W    = 3;
	localparam int COUNT_W   = 5;

	// Configuration port.
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;
	localparam int WS_W       = 5;
	localparam logic [APB_ADDR_W-1:0] REG_WINDOW_SIZE_ADDR = 2'd0;
	localparam logic [WS_W-1:0]       WINDOW_SIZE_RESET    = 5'd16;

	// Request actions.
	localparam logic [ACTION_W-1:0] ACT_SEND    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ACK     = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TIMEOUT = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_XMIT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RETX   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ACKED  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_IDLE   = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              take_in;
		logic              load_slot;
		logic              reduce_slot;
		logic              push;
		logic              pop;
		logic              reduce_head;
		logic              emit;
		logic [KIND_W-1:0] kind;
	} swsu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                full;
		logic                empty;
		logic                slot_ge_w;
		logic                head_ge_w;
		logic                match;
		logic                out_free;
	} swsu_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swsu_ifs.sv -----
// ----------------------------------------------------------------------------
// swsu request and result channels
// Valid/ready channels that carry one request item and one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface swsu_req_if;
	logic                           valid;
	logic                           ready;
	logic [swsu_pkg::ACTION_W-1:0]  action;
	logic [swsu_pkg::PAYLOAD_W-1:0] payload;
	logic [swsu_pkg::SEQ_W-1:0]     ack_seq;

	modport source (output valid, action, payload, ack_seq, input ready);
	modport sink   (input valid, action, payload, ack_seq, output ready);
endinterface

interface swsu_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [swsu_pkg::KIND_W-1:0]    kind;
	logic [swsu_pkg::SEQ_W-1:0]     seq;
	logic [swsu_pkg::PAYLOAD_W-1:0] data_out;
	logic [swsu_pkg::COUNT_W-1:0]   released;
	logic [swsu_pkg::COUNT_W-1:0]   occupancy;

	modport source (output valid, kind, seq, data_out, released, occupancy, input ready);
	modport sink   (input valid, kind, seq, data_out, released, occupancy, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swsu_ctrl.sv -----
// ----------------------------------------------------------------------------
// swsu_ctrl
// Controller of the sender: sequences one request through slot reduction,
// acknowledgement popping and result issue.
// ----------------------------------------------------------------------------
`default_nettype none

module swsu_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire swsu_pkg::swsu_sts_t sts,
	output swsu_pkg::swsu_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SLOT = 2'd2;
	localparam logic [1:0] ST_ACK  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.kind = swsu_pkg::KIND_XMIT;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (sts.action)
					swsu_pkg::ACT_SEND: begin
						if (sts.full) begin
							if (sts.out_free) begin
								cmd.emit = 1'b1;
								cmd.kind = swsu_pkg::KIND_REJECT;
								state_d  = ST_IDLE;
							end
						end else begin
							cmd.load_slot = 1'b1;
							state_d       = ST_SLOT;
						end
					end
					swsu_pkg::ACT_ACK: begin
						state_d = ST_ACK;
					end
					swsu_pkg::ACT_TIMEOUT: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.kind = sts.empty ? swsu_pkg::KIND_IDLE : swsu_pkg::KIND_RETX;
							state_d  = ST_IDLE;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_SLOT: begin
				if (sts.slot_ge_w) begin
					cmd.reduce_slot = 1'b1;
				end else if (sts.out_free) begin
					cmd.push = 1'b1;
					cmd.emit = 1'b1;
					cmd.kind = swsu_pkg::KIND_XMIT;
					state_d  = ST_IDLE;
				end
			end
			ST_ACK: begin
				if (sts.head_ge_w) begin
					cmd.reduce_head = 1'b1;
				end else if (sts.empty || sts.match) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.kind = swsu_pkg::KIND_ACKED;
						state_d  = ST_IDLE;
					end
				end else begin
					cmd.pop = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/swsu_dp.sv -----
// ----------------------------------------------------------------------------
// swsu_dp
// Datapath of the sender: window ring memory, head/count/sequence registers,
// slot reducer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swsu_dp #(
	parameter int WINDOW_DEPTH = swsu_pkg::WINDOW_DEPTH_DEF,
	parameter int SEQ_COUNT    = swsu_pkg::SEQ_COUNT_DEF,
	parameter int PAYLOAD_BITS = swsu_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [swsu_pkg::WS_W-1:0]      window_size,
	input  wire logic [swsu_pkg::ACTION_W-1:0]  in_action,
	input  wire logic [swsu_pkg::PAYLOAD_W-1:0] in_payload,
	input  wire logic [swsu_pkg::SEQ_W-1:0]     in_ack_seq,
	input  wire swsu_pkg::swsu_cmd_t            cmd,
	output swsu_pkg::swsu_sts_t                 sts,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [swsu_pkg::KIND_W-1:0]         out_kind,
	output logic [swsu_pkg::SEQ_W-1:0]          out_seq,
	output logic [swsu_pkg::PAYLOAD_W-1:0]      out_data,
	output logic [swsu_pkg::COUNT_W-1:0]        out_released,
	output logic [swsu_pkg::COUNT_W-1:0]        out_occupancy
);

	localparam int CW   = $clog2(WINDOW_DEPTH + 1);
	localparam int SLW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int RW   = CW + 1;
	localparam int SW   = $clog2(SEQ_COUNT);
	localparam int CMPW = (SW > swsu_pkg::SEQ_W) ? SW : swsu_pkg::SEQ_W;
	localparam int WSX  = (CW > swsu_pkg::WS_W) ? CW : swsu_pkg::WS_W;
	localparam logic [WSX-1:0] DEPTH_X  = WSX'(WINDOW_DEPTH);
	localparam logic [SW-1:0]  SEQ_LAST = SW'(SEQ_COUNT - 1);

	// Window ring memory, one write and one registered read port.
	logic [SW-1:0]           seq_mem  [WINDOW_DEPTH];
	logic [PAYLOAD_BITS-1:0] data_mem [WINDOW_DEPTH];
	logic [SW-1:0]           rd_seq_q;
	logic [PAYLOAD_BITS-1:0] rd_data_q;

	logic [SLW-1:0]                  head_q;
	logic [CW-1:0]                   cnt_q;
	logic [SW-1:0]                   nseq_q;
	logic                            hred_q;
	logic [RW-1:0]                   slot_q;
	logic [CW-1:0]                   rel_q;
	logic [swsu_pkg::ACTION_W-1:0]   act_q;
	logic [PAYLOAD_BITS-1:0]         pay_q;
	logic [swsu_pkg::SEQ_W-1:0]      ack_q;
	logic                            ovalid_q;
	logic [swsu_pkg::KIND_W-1:0]     okind_q;
	logic [swsu_pkg::SEQ_W-1:0]      oseq_q;
	logic [swsu_pkg::PAYLOAD_W-1:0]  odata_q;
	logic [swsu_pkg::COUNT_W-1:0]    orel_q;
	logic [swsu_pkg::COUNT_W-1:0]    oocc_q;

	logic [WSX-1:0] ws_x;
	logic [CW-1:0]  w_eff;
	logic [CW-1:0]  head_inc;
	logic [CW-1:0]  head_step;
	logic [CW-1:0]  head_sub;
	logic [SLW-1:0] head_d;
	logic           hred_d;
	logic [CMPW-1:0] rd_seq_x;
	logic [CMPW-1:0] ack_x;
	logic [CMPW-1:0] seq_sel;
	logic [CMPW-1:0] nseq_x;
	logic           out_free;

	// Window size 0 acts as 1, sizes beyond the ring act as the ring depth.
	always_comb begin
		ws_x = WSX'(window_size);
		if (window_size == '0) begin
			w_eff = CW'(1);
		end else if (ws_x > DEPTH_X) begin
			w_eff = CW'(WINDOW_DEPTH);
		end else begin
			w_eff = CW'(ws_x);
		end
	end

	// Head advance is one conditional subtract; a head left above a shrunk
	// window needs further subtract steps, flagged by hred.
	always_comb begin
		head_inc  = CW'(head_q) + CW'(1);
		head_step = (head_inc >= w_eff) ? head_inc - w_eff : head_inc;
		head_sub  = CW'(head_q) - w_eff;
		head_d    = head_q;
		hred_d    = hred_q;
		if (cmd.pop) begin
			head_d = SLW'(head_step);
			hred_d = head_step >= w_eff;
		end else if (cmd.reduce_head) begin
			head_d = SLW'(head_sub);
			hred_d = head_sub >= w_eff;
		end
	end

	assign out_free = !ovalid_q || out_ready;
	assign rd_seq_x = CMPW'(rd_seq_q);
	assign ack_x    = CMPW'(ack_q);
	assign nseq_x   = CMPW'(nseq_q);

	always_comb begin
		sts.action    = act_q;
		sts.full      = cnt_q >= w_eff;
		sts.empty     = cnt_q == '0;
		sts.slot_ge_w = slot_q >= RW'(w_eff);
		sts.head_ge_w = hred_q;
		sts.match     = rd_seq_x == ack_x;
		sts.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			nseq_q <= '0;
			hred_q <= 1'b0;
		end else begin
			head_q <= head_d;
			hred_q <= hred_d;
			if (cmd.push) begin
				cnt_q  <= cnt_q + CW'(1);
				nseq_q <= (nseq_q == SEQ_LAST) ? '0 : nseq_q + SW'(1);
			end else if (cmd.pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Ring memory; the read follows the next head so rd_* shows the head entry.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			seq_mem[slot_q[SLW-1:0]]  <= nseq_q;
			data_mem[slot_q[SLW-1:0]] <= pay_q;
		end
		rd_seq_q  <= seq_mem[head_d];
		rd_data_q <= data_mem[head_d];
	end

	// Request capture, slot reduction and release counting.
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			act_q <= in_action;
			pay_q <= in_payload[PAYLOAD_BITS-1:0];
			ack_q <= in_ack_seq;
			rel_q <= '0;
		end else if (cmd.pop) begin
			rel_q <= rel_q + CW'(1);
		end
		if (cmd.load_slot) begin
			slot_q <= RW'(head_q) + RW'(cnt_q);
		end else if (cmd.reduce_slot) begin
			slot_q <= slot_q - RW'(w_eff);
		end
	end

	always_comb begin
		case (cmd.kind)
			swsu_pkg::KIND_XMIT:  seq_sel = nseq_x;
			swsu_pkg::KIND_RETX:  seq_sel = rd_seq_x;
			swsu_pkg::KIND_ACKED: seq_sel = ack_x;
			default:              seq_sel = '0;
		endcase
	end

	// Result register; it holds until taken while the next request proceeds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			okind_q <= cmd.kind;
			oseq_q  <= seq_sel[swsu_pkg::SEQ_W-1:0];
			if (cmd.kind == swsu_pkg::KIND_XMIT) begin
				odata_q <= swsu_pkg::PAYLOAD_W'(pay_q);
			end else if (cmd.kind == swsu_pkg::KIND_RETX) begin
				odata_q <= swsu_pkg::PAYLOAD_W'(rd_data_q);
			end else begin
				odata_q <= '0;
			end
			orel_q <= (cmd.kind == swsu_pkg::KIND_ACKED) ? swsu_pkg::COUNT_W'(rel_q) : '0;
			oocc_q <= cmd.push ? swsu_pkg::COUNT_W'(cnt_q + CW'(1))
				: swsu_pkg::COUNT_W'(cnt_q);
		end
	end

	assign out_valid     = ovalid_q;
	assign out_kind      = okind_q;
	assign out_seq       = oseq_q;
	assign out_data      = odata_q;
	assign out_released  = orel_q;
	assign out_occupancy = oocc_q;

	// A new entry is only stored into a window with room left.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (cnt_q < w_eff))
		else $error("push into a full window");

	// Entries are only popped from a non-empty window.
	a_pop_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (cnt_q != '0))
		else $error("pop from an empty window");

	// A result never overwrites one that has not been taken.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result register overwritten");

	// The occupancy never goes past the ring depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(WINDOW_DEPTH))
		else $error("window count beyond ring depth");

	// A pop moves the count down by exactly one.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> (cnt_q == $past(cnt_q) - CW'(1)))
		else $error("pop did not release one entry");

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_sender_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_sender_unit
// Sender side of a sliding-window link: stores sent words in a ring, pops
// them on acknowledgement and hands back the head word on a timeout.
// ----------------------------------------------------------------------------
// Usage:
// Each request item on req carries an action (send, acknowledgement or
// timeout), a payload word and an acknowledged sequence number. Every send,
// acknowledgement and timeout gives exactly one result item on rsp; an
// unknown action is dropped without a result.
// An item's result is registered when its last step issues it, and only
// then does the controller go back to accepting the next item.
// A send loads its ring slot as head plus count and takes one subtract step
// for each wrap of the slot: one when head plus count wraps past the window
// size, more after the window was shrunk. A timeout issues its result as its
// only step. An acknowledgement takes one step for each released entry,
// since the head entry is read from the ring's single registered read port
// once per pop, plus one for each subtract step of a head left beyond a
// shrunk window. One item is worked on at a time.
// The result sits in an output register: a new request is accepted while an
// earlier result waits, and only issuing the next result waits for rsp.ready.
// Reset empties the window, zeroes the head and the sequence counter, and
// sets window_size to 16; ring contents stay unknown until written.
// window_size sits at APB byte address 0 and may be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sender_unit #(
	parameter int WINDOW_DEPTH = swsu_pkg::WINDOW_DEPTH_DEF,
	parameter int SEQ_COUNT    = swsu_pkg::SEQ_COUNT_DEF,
	parameter int PAYLOAD_BITS = swsu_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	swsu_req_if.sink                              req,
	swsu_rsp_if.source                            rsp,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [swsu_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [swsu_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [swsu_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready
);

	logic [swsu_pkg::WS_W-1:0] window_size_q;
	logic                      in_ready;
	swsu_pkg::swsu_cmd_t       cmd;
	swsu_pkg::swsu_sts_t       sts;

	// The configuration port never waits; the single register decodes at
	// byte address zero and takes the low bits of the write data.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swsu_pkg::WINDOW_SIZE_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr == swsu_pkg::REG_WINDOW_SIZE_ADDR)) begin
			window_size_q <= pwdata[swsu_pkg::WS_W-1:0];
		end
	end

	assign prdata = (paddr == swsu_pkg::REG_WINDOW_SIZE_ADDR)
		? swsu_pkg::APB_DATA_W'(window_size_q) : '0;

	// The controller only sequences; all state of the window is in the datapath.
	swsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign req.ready = in_ready;

	swsu_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SEQ_COUNT    (SEQ_COUNT),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.window_size   (window_size_q),
		.in_action     (req.action),
		.in_payload    (req.payload),
		.in_ack_seq    (req.ack_seq),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_kind      (rsp.kind),
		.out_seq       (rsp.seq),
		.out_data      (rsp.data_out),
		.out_released  (rsp.released),
		.out_occupancy (rsp.occupancy)
	);

endmodule

`default_nettype wire
